// ----- sv/dab_pkg.sv -----
// Shared types and constants for the debounce and autorepeat button block.
package dab_pkg;

	// Number of button fields carried by one poll sample and one result.
	localparam int unsigned NUM_FIELDS = 4;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_DEB   = 2'd1,
		PH_FIRED = 2'd2
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE      = 3'd0,
		REG_START_DELAY   = 3'd1,
		REG_PERIOD_LEFT   = 3'd2,
		REG_PERIOD_RIGHT  = 3'd3,
		REG_PERIOD_ROTATE = 3'd4,
		REG_PERIOD_DROP   = 3'd5
	} cfg_reg_t;

	// Timing settings seen by one button lane.
	typedef struct packed {
		logic [CFG_W-1:0] debounce_time;
		logic [CFG_W-1:0] repeat_start_delay;
		logic [CFG_W-1:0] repeat_period;
	} lane_cfg_t;

endpackage

// ----- sv/debounce_autorepeat_buttons.sv -----
// Top level: configuration registers, one lane per button and the result merge.
// A result is registered in the output entry as its sample is transferred.
// Throughput: one sample per cycle unless stalled; every lane updates on a transfer.
// A second output entry takes the sample transferred in the first stalled output cycle,
// so in_stall rises in the next cycle and holds until that entry moves on.
// Reset: all buttons idle with zero timestamps, registers at their default values.
module debounce_autorepeat_buttons
	import dab_pkg::*;
#(
	parameter int unsigned NUM_BUTTONS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [TIME_W-1:0]    now_ms,
	input  logic                 pressed_left,
	input  logic                 pressed_right,
	input  logic                 pressed_rotate,
	input  logic                 pressed_drop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 fire_left,
	output logic                 fire_right,
	output logic                 fire_rotate,
	output logic                 fire_drop,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [CFG_W-1:0] debounce_q;
	logic [CFG_W-1:0] start_delay_q;
	logic [CFG_W-1:0] period_q [NUM_FIELDS];

	logic                  in_xfer;
	logic                  merge_busy;
	logic [NUM_FIELDS-1:0] pressed_fields;
	logic [NUM_FIELDS-1:0] lane_fields;
	logic [NUM_FIELDS-1:0] result_fields;
	logic [NUM_BUTTONS-1:0] lane_fire;

	assign cfg_ready = 1'b1;
	assign in_stall  = merge_busy;
	assign in_xfer   = in_valid && !merge_busy;

	assign pressed_fields = {pressed_drop, pressed_rotate, pressed_right, pressed_left};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q    <= 16'd20;
			start_delay_q <= 16'd300;
			period_q[0]   <= 16'd100;
			period_q[1]   <= 16'd100;
			period_q[2]   <= 16'd0;
			period_q[3]   <= 16'd50;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DEBOUNCE:      debounce_q    <= cfg_data;
				REG_START_DELAY:   start_delay_q <= cfg_data;
				REG_PERIOD_LEFT:   period_q[0]   <= cfg_data;
				REG_PERIOD_RIGHT:  period_q[1]   <= cfg_data;
				REG_PERIOD_ROTATE: period_q[2]   <= cfg_data;
				REG_PERIOD_DROP:   period_q[3]   <= cfg_data;
				default: ;
			endcase
		end
	end

	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
		lane_cfg_t lane_cfg;
		logic      lane_pressed;

		// Buttons without an input field stay released and never repeat.
		if (i < NUM_FIELDS) begin : g_field
			assign lane_pressed           = pressed_fields[i];
			assign lane_cfg.repeat_period = period_q[i];
		end else begin : g_spare
			assign lane_pressed           = 1'b0;
			assign lane_cfg.repeat_period = '0;
		end
		assign lane_cfg.debounce_time      = debounce_q;
		assign lane_cfg.repeat_start_delay = start_delay_q;

		dab_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.step    (in_xfer),
			.now_ms  (now_ms),
			.pressed (lane_pressed),
			.cfg     (lane_cfg),
			.fire    (lane_fire[i])
		);
	end

	for (genvar j = 0; j < NUM_FIELDS; j++) begin : g_field_out
		if (j < NUM_BUTTONS) begin : g_used
			assign lane_fields[j] = lane_fire[j];
		end else begin : g_unused
			assign lane_fields[j] = 1'b0;
		end
	end

	dab_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (in_xfer),
		.lane_fire   (lane_fields),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.fire_fields (result_fields),
		.busy        (merge_busy)
	);

	assign fire_left   = result_fields[0];
	assign fire_right  = result_fields[1];
	assign fire_rotate = result_fields[2];
	assign fire_drop   = result_fields[3];

endmodule

// ----- sv/dab_lane.sv -----
// One button lane: idle, debouncing and fired machine with autorepeat timing.
module dab_lane
	import dab_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [TIME_W-1:0] now_ms,
	input  logic              pressed,
	input  lane_cfg_t         cfg,
	output logic              fire
);

	phase_t            phase_q, phase_d;
	logic [TIME_W-1:0] press_start_q, press_start_d;
	logic [TIME_W-1:0] last_fire_q, last_fire_d;
	logic              in_repeat_q, in_repeat_d;

	logic [TIME_W-1:0] held_time;
	logic [TIME_W-1:0] since_fire;
	logic [CFG_W-1:0]  wait_time;

	assign held_time  = now_ms - press_start_q;
	assign since_fire = now_ms - last_fire_q;
	assign wait_time  = in_repeat_q ? cfg.repeat_period : cfg.repeat_start_delay;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			press_start_q <= '0;
			last_fire_q   <= '0;
			in_repeat_q   <= 1'b0;
		end else if (step) begin
			phase_q       <= phase_d;
			press_start_q <= press_start_d;
			last_fire_q   <= last_fire_d;
			in_repeat_q   <= in_repeat_d;
		end
	end

	always_comb begin
		phase_d       = phase_q;
		press_start_d = press_start_q;
		last_fire_d   = last_fire_q;
		in_repeat_d   = in_repeat_q;
		fire          = 1'b0;
		unique case (phase_q)
			PH_DEB: begin
				if (!pressed) begin
					phase_d = PH_IDLE;
				end else if (held_time >= {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_time}) begin
					phase_d     = PH_FIRED;
					last_fire_d = now_ms;
					in_repeat_d = 1'b0;
					fire        = 1'b1;
				end
			end
			PH_FIRED: begin
				if (!pressed) begin
					phase_d     = PH_IDLE;
					in_repeat_d = 1'b0;
				end else if (cfg.repeat_period != '0 &&
					since_fire >= {{(TIME_W-CFG_W){1'b0}}, wait_time}) begin
					last_fire_d = now_ms;
					in_repeat_d = 1'b1;
					fire        = 1'b1;
				end
			end
			default: begin
				// The unused phase code behaves as idle.
				phase_d = PH_IDLE;
				if (pressed) begin
					phase_d       = PH_DEB;
					press_start_d = now_ms;
					in_repeat_d   = 1'b0;
				end
			end
		endcase
	end

endmodule

// ----- sv/dab_merge.sv -----
// Merges the lane fire flags into one result and buffers it with a skid stage.
module dab_merge
	import dab_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [NUM_FIELDS-1:0] lane_fire,
	input  logic                  out_stall,
	output logic                  out_valid,
	output logic [NUM_FIELDS-1:0] fire_fields,
	output logic                  busy
);

	logic                  out_valid_q;
	logic [NUM_FIELDS-1:0] out_fire_q;
	logic                  skid_valid_q;
	logic [NUM_FIELDS-1:0] skid_fire_q;
	logic                  drain;

	assign drain       = out_valid_q && !out_stall;
	assign out_valid   = out_valid_q;
	assign fire_fields = out_fire_q;
	// A full skid stage holds off the next sample.
	assign busy        = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (drain) begin
				skid_valid_q <= 1'b0;
			end
		end else if (take) begin
			if (!out_valid_q || drain) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (drain) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (drain) begin
				out_fire_q <= skid_fire_q;
			end
		end else if (take) begin
			if (!out_valid_q || drain) begin
				out_fire_q <= lane_fire;
			end else begin
				skid_fire_q <= lane_fire;
			end
		end
	end

endmodule

// ----- sim/button_fire_checker.sv -----
// Checker for the button block: predicts each sample's fire pattern and compares results.
module button_fire_checker
	import dab_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [TIME_W-1:0]    now_ms,
	input  logic                 pressed_left,
	input  logic                 pressed_right,
	input  logic                 pressed_rotate,
	input  logic                 pressed_drop,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 fire_left,
	input  logic                 fire_right,
	input  logic                 fire_rotate,
	input  logic                 fire_drop,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int unsigned          mismatches,
	output int unsigned          pending,
	output int unsigned          samples_seen,
	output int unsigned          fires_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_W-1:0] DEBOUNCE_DEFAULT    = 16'd20;
	localparam logic [CFG_W-1:0] START_DELAY_DEFAULT = 16'd300;
	localparam logic [CFG_W-1:0] PERIOD_DEFAULT [NUM_FIELDS] = '{16'd100, 16'd100, 16'd0, 16'd50};

	string lane_name [NUM_FIELDS] = '{"left", "right", "rotate", "drop"};

	// Timing settings as last written through the register port.
	logic [CFG_W-1:0] debounce_cfg;
	logic [CFG_W-1:0] start_delay_ms;
	logic [CFG_W-1:0] period_ms [NUM_FIELDS];

	// Per-button qualifier state.
	phase_t            lane_phase [NUM_FIELDS];
	logic [TIME_W-1:0] press_at   [NUM_FIELDS];
	logic [TIME_W-1:0] fired_at   [NUM_FIELDS];
	logic              repeating  [NUM_FIELDS];

	logic [NUM_FIELDS-1:0] expected_fires [$];
	logic [NUM_FIELDS-1:0] want;
	logic [NUM_FIELDS-1:0] got;

	// Advances every button by one poll sample and returns the buttons that fire.
	function automatic logic [NUM_FIELDS-1:0] qualify_sample(
		input logic [TIME_W-1:0]     now,
		input logic [NUM_FIELDS-1:0] level
	);
		logic [NUM_FIELDS-1:0] fires;
		logic [TIME_W-1:0]     elapsed;
		logic [TIME_W-1:0]     hold_ms;
		fires = '0;
		for (int b = 0; b < NUM_FIELDS; b++) begin
			case (lane_phase[b])
				PH_DEB: begin
					elapsed = now - press_at[b];
					if (!level[b]) begin
						lane_phase[b] = PH_IDLE;
					end else if (elapsed >= TIME_W'(debounce_cfg)) begin
						lane_phase[b] = PH_FIRED;
						fired_at[b]   = now;
						repeating[b]  = 1'b0;
						fires[b]      = 1'b1;
					end
				end
				PH_FIRED: begin
					elapsed = now - fired_at[b];
					hold_ms = repeating[b] ? TIME_W'(period_ms[b]) : TIME_W'(start_delay_ms);
					if (!level[b]) begin
						lane_phase[b] = PH_IDLE;
						repeating[b]  = 1'b0;
					end else if (period_ms[b] != '0 && elapsed >= hold_ms) begin
						fired_at[b]  = now;
						repeating[b] = 1'b1;
						fires[b]     = 1'b1;
					end
				end
				default: begin
					lane_phase[b] = PH_IDLE;
					if (level[b]) begin
						lane_phase[b] = PH_DEB;
						press_at[b]   = now;
						repeating[b]  = 1'b0;
					end
				end
			endcase
		end
		return fires;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_cfg   = DEBOUNCE_DEFAULT;
			start_delay_ms = START_DELAY_DEFAULT;
			for (int b = 0; b < NUM_FIELDS; b++) begin
				period_ms[b]  = PERIOD_DEFAULT[b];
				lane_phase[b] = PH_IDLE;
				press_at[b]   = '0;
				fired_at[b]   = '0;
				repeating[b]  = 1'b0;
			end
			expected_fires.delete();
			mismatches   = 0;
			pending      = 0;
			samples_seen = 0;
			fires_seen   = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DEBOUNCE:      debounce_cfg   = cfg_data;
					REG_START_DELAY:   start_delay_ms = cfg_data;
					REG_PERIOD_LEFT:   period_ms[0]   = cfg_data;
					REG_PERIOD_RIGHT:  period_ms[1]   = cfg_data;
					REG_PERIOD_ROTATE: period_ms[2]   = cfg_data;
					REG_PERIOD_DROP:   period_ms[3]   = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				expected_fires.push_back(qualify_sample(now_ms,
					{pressed_drop, pressed_rotate, pressed_right, pressed_left}));
				samples_seen++;
			end
			if (out_valid && !out_stall) begin
				got = {fire_drop, fire_rotate, fire_right, fire_left};
				if (expected_fires.size() == 0) begin
					if (mismatches < 10)
						$display("ERROR: result %b arrived with no sample outstanding", got);
					mismatches++;
				end else begin
					want = expected_fires.pop_front();
					fires_seen += $countones(got);
					for (int b = 0; b < NUM_FIELDS; b++) begin
						if (got[b] !== want[b]) begin
							if (mismatches < 10)
								$display("ERROR: fire_%s expected %b, got %b (result %0d)",
									lane_name[b], want[b], got[b],
									samples_seen - expected_fires.size() - 1);
							mismatches++;
						end
					end
				end
			end
			pending = expected_fires.size();
		end
	end

endmodule

// ----- sim/tb_debounce_autorepeat_buttons.sv -----
// Testbench top: clock, reset, sample and register stimulus, output stall and verdict.
module tb_debounce_autorepeat_buttons
	import dab_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 210;
	localparam int HOLD_OFF_CYCLES = 200;
	// Indexes with no register behind them; writes there must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [TIME_W-1:0]    now_ms;
	logic                 pressed_left;
	logic                 pressed_right;
	logic                 pressed_rotate;
	logic                 pressed_drop;
	logic                 out_valid;
	logic                 out_stall;
	logic                 fire_left;
	logic                 fire_right;
	logic                 fire_rotate;
	logic                 fire_drop;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	int unsigned mismatches;
	int unsigned pending;
	int unsigned samples_seen;
	int unsigned fires_seen;

	int tx_idle_pct;
	int rx_stall_pct;
	int rx_hold_left;
	int step_max;
	int settings_used;

	debounce_autorepeat_buttons dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.now_ms        (now_ms),
		.pressed_left  (pressed_left),
		.pressed_right (pressed_right),
		.pressed_rotate(pressed_rotate),
		.pressed_drop  (pressed_drop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.fire_left     (fire_left),
		.fire_right    (fire_right),
		.fire_rotate   (fire_rotate),
		.fire_drop     (fire_drop),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	button_fire_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.now_ms        (now_ms),
		.pressed_left  (pressed_left),
		.pressed_right (pressed_right),
		.pressed_rotate(pressed_rotate),
		.pressed_drop  (pressed_drop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.fire_left     (fire_left),
		.fire_right    (fire_right),
		.fire_rotate   (fire_rotate),
		.fire_drop     (fire_drop),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.pending       (pending),
		.samples_seen  (samples_seen),
		.fires_seen    (fires_seen)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Output side: random stall, or a counted hold-off when one is requested.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_left > 0) begin
				out_stall <= 1'b1;
				rx_hold_left--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
			end
		end
	end

	// Offers one poll sample and returns at the edge where it is transferred.
	task automatic offer_sample(input logic [TIME_W-1:0] t, input logic [NUM_FIELDS-1:0] lv);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		now_ms         <= t;
		pressed_left   <= lv[0];
		pressed_right  <= lv[1];
		pressed_rotate <= lv[2];
		pressed_drop   <= lv[3];
		do @(posedge clk); while (in_stall);
	endtask

	// Leaves cfg_valid high; the caller lowers it after the last write of a batch.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	function automatic logic [CFG_W-1:0] pick_period();
		int r;
		r = $urandom_range(0, 7);
		if (r < 2)
			return '0;
		else if (r == 7)
			return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd1;
		return CFG_W'($urandom_range(1, 60));
	endfunction

	task automatic program_timing(input int phase_no);
		logic [CFG_W-1:0] deb;
		logic [CFG_W-1:0] start;
		if (phase_no == 0) begin
			deb   = 16'd20;
			start = 16'd300;
		end else if (phase_no == 5) begin
			deb   = CFG_W'($urandom());
			start = CFG_W'($urandom());
		end else begin
			deb   = CFG_W'($urandom_range(0, 40));
			start = CFG_W'($urandom_range(0, 200));
		end
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_START_DELAY, start);
		for (int b = 0; b < NUM_FIELDS; b++)
			write_reg(CFG_IDX_W'(REG_PERIOD_LEFT + b), pick_period());
		cfg_valid <= 1'b0;
		step_max = (int'(deb) + int'(start)) / 6 + 3;
		settings_used++;
	endtask

	initial begin
		logic [TIME_W-1:0]     t;
		logic [NUM_FIELDS-1:0] level;
		int                    chatter_left;
		int                    r;

		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		now_ms         <= '0;
		pressed_left   <= 1'b0;
		pressed_right  <= 1'b0;
		pressed_rotate <= 1'b0;
		pressed_drop   <= 1'b0;
		cfg_valid      <= 1'b0;
		cfg_index      <= REG_DEBOUNCE;
		cfg_data       <= '0;
		tx_idle_pct   = 30;
		rx_stall_pct  = 30;
		rx_hold_left  = 0;
		settings_used = 1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset timing: debounce edge, start delay, per-button periods, release,
		// and a timestamp that steps backwards.
		offer_sample(32'd0, 4'b0000);
		offer_sample(32'd1000, 4'b1111);
		offer_sample(32'd1019, 4'b1111);
		offer_sample(32'd1020, 4'b1111);
		offer_sample(32'd1319, 4'b1111);
		offer_sample(32'd1320, 4'b1111);
		offer_sample(32'd1370, 4'b1111);
		offer_sample(32'd1420, 4'b1010);
		offer_sample(32'd1420, 4'b1010);
		offer_sample(32'h0000_0100, 4'b1111);
		offer_sample(32'hFFFF_FFFF, 4'b0000);

		// Zero debounce and start delay: the press sample itself must not fire.
		drain_results();
		write_reg(REG_DEBOUNCE, 16'd0);
		write_reg(REG_START_DELAY, 16'd0);
		write_reg(REG_PERIOD_LEFT, 16'd1);
		write_reg(REG_PERIOD_RIGHT, 16'hFFFF);
		write_reg(REG_PERIOD_ROTATE, 16'd0);
		write_reg(REG_PERIOD_DROP, 16'd2);
		cfg_valid <= 1'b0;
		settings_used++;
		offer_sample(32'hFFFF_FFF0, 4'b1111);
		offer_sample(32'hFFFF_FFF0, 4'b1111);
		offer_sample(32'hFFFF_FFF0, 4'b1111);
		offer_sample(32'hFFFF_FFF0, 4'b1111);
		offer_sample(32'h0000_0005, 4'b1111);
		offer_sample(32'h0000_0005, 4'b0000);

		// Largest debounce and start delay; writes to unmapped indexes are ignored.
		drain_results();
		write_reg(REG_DEBOUNCE, 16'hFFFF);
		write_reg(REG_START_DELAY, 16'hFFFF);
		write_reg(REG_SPARE_A, 16'd0);
		write_reg(REG_SPARE_B, 16'd0);
		cfg_valid <= 1'b0;
		settings_used++;
		offer_sample(32'h8000_0000, 4'b1111);
		offer_sample(32'h8000_FFFE, 4'b1111);
		offer_sample(32'h8000_FFFF, 4'b1111);
		offer_sample(32'h8001_FFFD, 4'b1111);
		offer_sample(32'h8001_FFFE, 4'b1111);
		offer_sample(32'h8001_FFFF, 4'b1111);

		for (int phase_no = 0; phase_no < NUM_PHASES; phase_no++) begin
			drain_results();
			program_timing(phase_no);
			tx_idle_pct  = (phase_no == 3) ? 0 : 30;
			rx_stall_pct = (phase_no == 3) ? 0 : 30;
			t            = $urandom();
			level        = '0;
			chatter_left = 0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (phase_no == 2 && n == 40)
					rx_hold_left = HOLD_OFF_CYCLES;
				if (phase_no == 2 && n == 120)
					drain_results();
				if (chatter_left == 0 && $urandom_range(0, 99) < 3)
					chatter_left = $urandom_range(3, 8);
				// Buttons are mostly held or released for a while, with bursts of contact bounce.
				for (int b = 0; b < NUM_FIELDS; b++) begin
					if ($urandom_range(0, 99) < ((chatter_left > 0) ? 50 : 4))
						level[b] = ~level[b];
				end
				if (chatter_left > 0)
					chatter_left--;
				if ($urandom_range(0, 99) < 5)
					level = NUM_FIELDS'($urandom());
				r = $urandom_range(0, 99);
				if (r < 2)
					t = $urandom();
				else if (r < 4)
					t = t - TIME_W'($urandom_range(1, step_max));
				else
					t = t + TIME_W'($urandom_range(0, step_max));
				offer_sample(t, level);
			end
		end

		drain_results();
		repeat (4) @(posedge clk);
		$display("Run covered %0d samples and %0d button fires over %0d timing settings,",
			samples_seen, fires_seen, settings_used);
		$display("with contact bounce, wrapping and backward timestamps, and output hold-off.");
		if (mismatches == 0 && pending == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- debounce_autorepeat_buttons.f -----
sv/dab_pkg.sv
sv/dab_lane.sv
sv/dab_merge.sv
sv/debounce_autorepeat_buttons.sv
sim/button_fire_checker.sv
sim/tb_debounce_autorepeat_buttons.sv
